// ----- src/desk_uart_frame_parser_assert.svh -----
// Assertion macros for the frame parser RTL.
// Each macro expects signals named clk and rst_n in the enclosing module.
`ifndef DESK_UART_FRAME_PARSER_ASSERT_SVH
`define DESK_UART_FRAME_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define DUFP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define DUFP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dufp_pkg.sv -----
// Shared types and constants for the UART frame parser.
// No dependencies; imported by every module of the block.
package dufp_pkg;

    localparam logic [7:0] SYNC_RESET  = 8'hF2;
    localparam logic [7:0] END_RESET   = 8'h7E;
    localparam logic [7:0] CMD_HEIGHT  = 8'h01;
    localparam logic [7:0] CMD_SLOT_LO = 8'h25;
    localparam logic [7:0] CMD_SLOT_HI = 8'h28;

    localparam logic [1:0] KIND_HEIGHT = 2'd0;
    localparam logic [1:0] KIND_SLOT   = 2'd1;
    localparam logic [1:0] KIND_OTHER  = 2'd2;

    localparam logic REG_SYNC = 1'b0;
    localparam logic REG_END  = 1'b1;

    typedef enum logic [6:0] {
        PH_SYNC1 = 7'b0000001,
        PH_SYNC2 = 7'b0000010,
        PH_CMD   = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_DATA  = 7'b0010000,
        PH_CSUM  = 7'b0100000,
        PH_END   = 7'b1000000
    } phase_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  slot;
        logic [7:0]  command;
        logic [15:0] value;
        logic [7:0]  length;
    } report_t;

endpackage

// ----- src/dufp_track.sv -----
// Frame tracking state machine: sync hunt, header, payload, checksum, end byte.
// Depends on dufp_pkg and desk_uart_frame_parser_assert.svh.
`include "desk_uart_frame_parser_assert.svh"

module dufp_track (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  logic [7:0]        rx_data,
    input  logic [7:0]        sync_val,
    input  logic [7:0]        end_val,
    output logic              rpt_push,
    output dufp_pkg::report_t rpt
);
    import dufp_pkg::*;

    phase_t     phase_reg, phase_next;
    logic [7:0] cmd_reg, cmd_next;
    logic [7:0] len_reg, len_next;
    logic [7:0] taken_reg, taken_next;
    logic [7:0] sum_reg, sum_next;
    logic [7:0] head0_reg, head0_next;
    logic [7:0] head1_reg, head1_next;
    logic [7:0] taken_inc;

    assign taken_inc = taken_reg + 8'd1;

    always_comb
    begin
        phase_next = phase_reg;
        cmd_next   = cmd_reg;
        len_next   = len_reg;
        taken_next = taken_reg;
        sum_next   = sum_reg;
        head0_next = head0_reg;
        head1_next = head1_reg;
        rpt_push   = 1'b0;
        if (step)
        begin
            unique case (phase_reg)
                PH_SYNC1:
                begin
                    if (rx_data == sync_val)
                    begin
                        phase_next = PH_SYNC2;
                    end
                end
                PH_SYNC2:
                begin
                    if (rx_data == sync_val)
                    begin
                        phase_next = PH_CMD;
                        sum_next   = 8'd0;
                    end
                    else
                    begin
                        phase_next = PH_SYNC1;
                    end
                end
                PH_CMD:
                begin
                    cmd_next   = rx_data;
                    sum_next   = sum_reg + rx_data;
                    phase_next = PH_LEN;
                end
                PH_LEN:
                begin
                    len_next   = rx_data;
                    taken_next = 8'd0;
                    head0_next = 8'd0;
                    head1_next = 8'd0;
                    sum_next   = sum_reg + rx_data;
                    phase_next = (rx_data == 8'd0) ? PH_CSUM : PH_DATA;
                end
                PH_DATA:
                begin
                    // Entry guarantees taken < length, so every byte here is payload.
                    if (taken_reg == 8'd0)
                    begin
                        head0_next = rx_data;
                    end
                    if (taken_reg == 8'd1)
                    begin
                        head1_next = rx_data;
                    end
                    sum_next   = sum_reg + rx_data;
                    taken_next = taken_inc;
                    if (taken_inc >= len_reg)
                    begin
                        phase_next = PH_CSUM;
                    end
                end
                PH_CSUM:
                begin
                    phase_next = (rx_data == sum_reg) ? PH_END : PH_SYNC1;
                end
                PH_END:
                begin
                    rpt_push   = (rx_data == end_val);
                    phase_next = PH_SYNC1;
                end
                default:
                begin
                    phase_next = PH_SYNC1;
                end
            endcase
        end
    end

    // Report decode works from the held frame fields.
    always_comb
    begin
        rpt.kind    = KIND_OTHER;
        rpt.slot    = 2'd0;
        rpt.command = cmd_reg;
        rpt.value   = {head0_reg, head1_reg};
        rpt.length  = len_reg;
        if (cmd_reg == CMD_HEIGHT)
        begin
            rpt.kind = KIND_HEIGHT;
        end
        else if (cmd_reg >= CMD_SLOT_LO && cmd_reg <= CMD_SLOT_HI)
        begin
            rpt.kind = KIND_SLOT;
            rpt.slot = 2'(cmd_reg - CMD_SLOT_LO);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SYNC1;
            cmd_reg   <= 8'd0;
            len_reg   <= 8'd0;
            taken_reg <= 8'd0;
            sum_reg   <= 8'd0;
            head0_reg <= 8'd0;
            head1_reg <= 8'd0;
        end
        else
        begin
            phase_reg <= phase_next;
            cmd_reg   <= cmd_next;
            len_reg   <= len_next;
            taken_reg <= taken_next;
            sum_reg   <= sum_next;
            head0_reg <= head0_next;
            head1_reg <= head1_next;
        end
    end

    `DUFP_ASSERT_NOW(a_push_from_end, rpt_push, step && phase_reg == PH_END,
        "report pushed outside the end byte phase")
    `DUFP_ASSERT_NOW(a_data_count, phase_reg == PH_DATA, taken_reg < len_reg,
        "payload phase with the byte count already at the length")
    `DUFP_ASSERT_NEXT(a_zero_len, step && phase_reg == PH_LEN && rx_data == 8'd0,
        phase_reg == PH_CSUM, "zero length did not go to the checksum phase")
    `DUFP_ASSERT_NEXT(a_end_done, step && phase_reg == PH_END,
        phase_reg == PH_SYNC1, "end byte phase did not return to the sync hunt")

endmodule

// ----- src/dufp_outreg.sv -----
// Result register holding one report until the downstream side takes it.
// Depends on dufp_pkg.
module dufp_outreg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dufp_pkg::report_t rpt,
    input  logic              out_stall,
    output logic              out_free,
    output logic              out_valid,
    output logic [1:0]        report_kind,
    output logic [1:0]        memory_slot,
    output logic [7:0]        frame_command,
    output logic [15:0]       reported_value,
    output logic [7:0]        payload_length
);
    import dufp_pkg::*;

    logic    vld_reg, vld_next;
    report_t rpt_reg;

    // A pending report may be replaced in the same cycle it is taken.
    assign out_free = !vld_reg || !out_stall;
    assign vld_next = push ? 1'b1 : (out_free ? 1'b0 : vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            rpt_reg <= rpt;
        end
    end

    assign out_valid      = vld_reg;
    assign report_kind    = rpt_reg.kind;
    assign memory_slot    = rpt_reg.slot;
    assign frame_command  = rpt_reg.command;
    assign reported_value = rpt_reg.value;
    assign payload_length = rpt_reg.length;

endmodule

// ----- src/desk_uart_frame_parser.sv -----
// A byte is registered on acceptance and stepped through the parser once the output
// register is free; out_valid is registered from the step that takes the end byte.
// Throughput: one byte per cycle while the output register is free; the output register is the only stall point.
// Reset: asynchronous, active low; the parser hunts the first sync byte and the
// sync and end byte registers return to 0xF2 and 0x7E.
module desk_uart_frame_parser (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  report_kind,
    output logic [1:0]  memory_slot,
    output logic [7:0]  frame_command,
    output logic [15:0] reported_value,
    output logic [7:0]  payload_length,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);
    import dufp_pkg::*;

    logic [7:0] sync_val_reg;
    logic [7:0] end_val_reg;
    logic       byte_vld_reg, byte_vld_next;
    logic [7:0] byte_reg;
    logic       out_free;
    logic       step;
    logic       accept;
    logic       rpt_push;
    report_t    rpt;

    assign step     = byte_vld_reg && out_free;
    assign in_stall = byte_vld_reg && !out_free;
    assign accept   = in_valid && !in_stall;
    assign byte_vld_next = accept ? 1'b1 : (step ? 1'b0 : byte_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_vld_reg <= 1'b0;
            sync_val_reg <= SYNC_RESET;
            end_val_reg  <= END_RESET;
        end
        else
        begin
            byte_vld_reg <= byte_vld_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SYNC: sync_val_reg <= cfg_data;
                    REG_END:  end_val_reg  <= cfg_data;
                    default:  sync_val_reg <= sync_val_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= rx_byte;
        end
    end

    dufp_track u_track (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .rx_data  (byte_reg),
        .sync_val (sync_val_reg),
        .end_val  (end_val_reg),
        .rpt_push (rpt_push),
        .rpt      (rpt)
    );

    dufp_outreg u_outreg (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (rpt_push),
        .rpt            (rpt),
        .out_stall      (out_stall),
        .out_free       (out_free),
        .out_valid      (out_valid),
        .report_kind    (report_kind),
        .memory_slot    (memory_slot),
        .frame_command  (frame_command),
        .reported_value (reported_value),
        .payload_length (payload_length)
    );

endmodule
